[rtl/core/crcf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// crcf_pkg: shared types, codes and CRC function of the CRC-16 frame engine
// Flags, mode and verdict codes, framer state and result group types, and
// the byte-wide CRC-16 (poly 0x8005, lsb-first data) update.
// ----------------------------------------------------------------------------
package crcf_pkg;

  localparam int unsigned MAX_FRAME_DEFAULT = 128;
  localparam int unsigned GROUP_DEPTH       = 4;

  localparam logic [15:0] CRC_POLY      = 16'h8005;
  localparam logic [7:0]  FLAG_COMMAND  = 8'h77;
  localparam logic [7:0]  FLAG_TRANSMIT = 8'h88;
  localparam logic [7:0]  FLAG_SLEEP    = 8'hCC;
  localparam logic [7:0]  MIN_COUNT     = 8'd3;
  localparam logic [7:0]  CRC_BYTES     = 8'd2;

  typedef enum logic [1:0] {
    MODE_COMMAND  = 2'd0,
    MODE_RESPONSE = 2'd1,
    MODE_TRANSMIT = 2'd2,
    MODE_SLEEP    = 2'd3
  } mode_t;

  typedef enum logic {
    KIND_BYTE    = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    VERDICT_OK        = 2'd0,
    VERDICT_CRC_BAD   = 2'd1,
    VERDICT_COUNT_BAD = 2'd2
  } verdict_t;

  typedef struct packed {
    logic [15:0] running_crc;
    logic [7:0]  frame_length;
    logic [7:0]  byte_position;
    logic        in_frame;
    logic [7:0]  received_crc_low;
  } state_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] out_byte;
    verdict_t   verdict;
    logic       last;
  } result_t;

  typedef result_t result_arr_t [GROUP_DEPTH];

  localparam state_t STATE_IDLE = '{
    running_crc: 16'h0000, frame_length: 8'd0, byte_position: 8'd0,
    in_frame: 1'b0, received_crc_low: 8'd0
  };

  localparam result_t RESULT_NONE = '{
    kind: KIND_BYTE, out_byte: 8'd0, verdict: VERDICT_OK, last: 1'b0
  };

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      if (b[i] ^ c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

[rtl/core/crc16_command_response_framer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// crc16_command_response_framer: CRC-16 command/response byte framer
// Frames command bytes with flag and CRC, checks response CRC, emits
// transmit and sleep flags.
// ----------------------------------------------------------------------------
// Each accepted byte passes an input register, one framing step and a result
// group register that holds up to four results and hands them out one per
// cycle while out_ready is high. A new byte is taken every cycle as long as
// each byte yields at most one result and out_ready is high; a byte with more
// results keeps the next byte in the input register until its last result is
// taken (a command frame start gives two, or four for a count of three, a
// frame end three). Response bytes that only feed the CRC give no result.
module crc16_command_response_framer #(
  parameter int unsigned MAX_FRAME = crcf_pkg::MAX_FRAME_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] mode,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       kind,
  output logic [7:0] out_byte,
  output logic [1:0] verdict,
  output logic       last
);
  import crcf_pkg::*;

  logic        pend_valid;
  logic [1:0]  pend_mode;
  logic [7:0]  pend_byte;

  state_t      st;
  state_t      st_next;
  result_arr_t eng_res;
  logic [2:0]  eng_cnt;

  result_arr_t grp_res;
  logic [2:0]  grp_left;
  logic [1:0]  grp_idx;

  logic        grp_free;
  logic        advance;
  logic        out_take;
  result_t     cur;

  crcf_engine #(
    .MAX_FRAME(MAX_FRAME)
  ) u_engine (
    .st      (st),
    .mode    (pend_mode),
    .in_byte (pend_byte),
    .st_next (st_next),
    .res     (eng_res),
    .cnt     (eng_cnt)
  );

  assign out_valid = (grp_left != 3'd0);
  assign out_take  = out_valid && out_ready;
  assign grp_free  = (grp_left == 3'd0) || (grp_left == 3'd1 && out_ready);
  assign advance   = pend_valid && grp_free;
  assign in_ready  = !pend_valid || advance;

  assign cur      = grp_res[grp_idx];
  assign kind     = cur.kind;
  assign out_byte = cur.out_byte;
  assign verdict  = cur.verdict;
  assign last     = cur.last;

  // hold the incoming byte until the result stage frees up
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      pend_valid <= 1'b1;
    end else if (advance) begin
      pend_valid <= 1'b0;
    end
    if (in_valid && in_ready) begin
      pend_mode <= mode;
      pend_byte <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_IDLE;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // load a new group or advance through the current one
  always_ff @(posedge clk) begin
    if (rst) begin
      grp_left <= 3'd0;
      grp_idx  <= 2'd0;
    end else if (advance) begin
      grp_left <= eng_cnt;
      grp_idx  <= 2'd0;
    end else if (out_take) begin
      grp_left <= grp_left - 3'd1;
      grp_idx  <= grp_idx + 2'd1;
    end
    if (advance) begin
      grp_res <= eng_res;
    end
  end

  a_group_bound: assert property (@(posedge clk) disable iff (rst)
    grp_left <= 3'd4)
    else $error("result group count out of range");

  a_last_is_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> grp_left == 3'd1)
    else $error("last flag on a result that is not the final one");

  a_group_shows: assert property (@(posedge clk) disable iff (rst)
    advance && eng_cnt != 3'd0 |=> out_valid)
    else $error("loaded result group not presented");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    !st.in_frame |-> st.byte_position == 8'd0 && st.running_crc == 16'h0000)
    else $error("idle framer holds frame state");

endmodule
`default_nettype wire

[rtl/core/crcf_engine.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// crcf_engine: per-byte framing step
// From the framer state and one input byte, forms the next state and the
// group of up to four results (flags, echoed bytes, CRC bytes, verdicts).
// ----------------------------------------------------------------------------
module crcf_engine #(
  parameter int unsigned MAX_FRAME = crcf_pkg::MAX_FRAME_DEFAULT
) (
  input  crcf_pkg::state_t      st,
  input  logic [1:0]            mode,
  input  logic [7:0]            in_byte,
  output crcf_pkg::state_t      st_next,
  output crcf_pkg::result_arr_t res,
  output logic [2:0]            cnt
);
  import crcf_pkg::*;

  localparam logic [7:0] MAX_LEN = 8'(MAX_FRAME);

  mode_t       md;
  logic [15:0] crc_new;
  logic [15:0] crc_first;
  logic [7:0]  pos_inc;
  logic [7:0]  body;
  logic        crc_ok;

  assign md        = mode_t'(mode);
  assign crc_new   = crc_feed(st.running_crc, in_byte);
  assign crc_first = crc_feed(16'h0000, in_byte);
  assign pos_inc   = (st.byte_position == 8'hFF) ? st.byte_position
                                                 : st.byte_position + 8'd1;
  assign body      = st.frame_length - CRC_BYTES;
  assign crc_ok    = (st.received_crc_low == st.running_crc[7:0]) &&
                     (in_byte == st.running_crc[15:8]);

  always_comb begin
    st_next = st;
    cnt     = 3'd0;
    for (int i = 0; i < GROUP_DEPTH; i++) begin
      res[i] = RESULT_NONE;
    end
    unique case (md)
      MODE_TRANSMIT, MODE_SLEEP: begin
        st_next         = STATE_IDLE;
        res[0].out_byte = (md == MODE_TRANSMIT) ? FLAG_TRANSMIT : FLAG_SLEEP;
        res[0].last     = 1'b1;
        cnt             = 3'd1;
      end
      MODE_COMMAND, MODE_RESPONSE: begin
        if (!st.in_frame) begin
          if (in_byte < MIN_COUNT || in_byte > MAX_LEN) begin
            st_next        = STATE_IDLE;
            res[0].kind    = KIND_VERDICT;
            res[0].verdict = VERDICT_COUNT_BAD;
            res[0].last    = 1'b1;
            cnt            = 3'd1;
          end else begin
            st_next.frame_length     = in_byte;
            st_next.byte_position    = 8'd1;
            st_next.in_frame         = 1'b1;
            st_next.received_crc_low = 8'd0;
            st_next.running_crc      = crc_first;
            if (md == MODE_COMMAND) begin
              res[0].out_byte = FLAG_COMMAND;
              res[1].out_byte = in_byte;
              cnt             = 3'd2;
              if (in_byte == MIN_COUNT) begin
                res[2].out_byte = crc_first[7:0];
                res[3].out_byte = crc_first[15:8];
                res[3].last     = 1'b1;
                cnt             = 3'd4;
                st_next         = STATE_IDLE;
              end
            end
          end
        end else if (md == MODE_COMMAND) begin
          st_next.running_crc   = crc_new;
          st_next.byte_position = pos_inc;
          res[0].out_byte       = in_byte;
          cnt                   = 3'd1;
          if (pos_inc >= body) begin
            res[1].out_byte = crc_new[7:0];
            res[2].out_byte = crc_new[15:8];
            res[2].last     = 1'b1;
            cnt             = 3'd3;
            st_next         = STATE_IDLE;
          end
        end else begin
          priority if (st.byte_position < body) begin
            st_next.running_crc   = crc_new;
            st_next.byte_position = pos_inc;
          end else if (st.byte_position == body) begin
            st_next.received_crc_low = in_byte;
            st_next.byte_position    = pos_inc;
          end else begin
            res[0].kind    = KIND_VERDICT;
            res[0].verdict = crc_ok ? VERDICT_OK : VERDICT_CRC_BAD;
            res[0].last    = 1'b1;
            cnt            = 3'd1;
            st_next        = STATE_IDLE;
          end
        end
      end
      default: begin
        st_next = st;
      end
    endcase
  end

endmodule
`default_nettype wire
